[rtl/bbe_pkg.sv]
// Shared types and constants of the edge-replicating box blur.
// No dependencies; the design modules of the block import this package.
package bbe_pkg;

  // Default largest window half width
  localparam int unsigned MaxRadiusDef = 63;
  // Width of the radius register
  localparam int unsigned RadiusW = 6;
  // Bits per color channel, also the number of quotient bits per divide
  localparam int unsigned ChanW = 8;
  // Color channels per pixel
  localparam int unsigned ChanCnt = 3;

  // One stored pixel
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // Incoming request payload
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic             line_end;
  } pix_req_t;

  // Result request payload
  typedef struct packed {
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_red;
    logic             out_line_last;
  } res_req_t;

  // Engine to output register: load strobe and line-last marker
  typedef struct packed {
    logic load;
    logic last;
  } res_load_t;

  // Engine sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_DRAIN,
    ST_START,
    ST_DIVIDE
  } eng_state_e;

  // Where one window tap comes from
  typedef enum logic [1:0] {
    SRC_NEWEST,
    SRC_FIRST,
    SRC_MEM
  } tap_src_e;

endpackage

[rtl/bbe_stream_if.sv]
// Valid/ready channel carrying one request payload of a chosen type.
// No dependencies; payload types come from bbe_pkg at instantiation.
interface bbe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/bbe_window_mem.sv]
// Ring store of the most recent pixels of a line, one write and one read port.
// Depends on bbe_pkg for the pixel type.
module bbe_window_mem #(
  parameter int unsigned MAX_RADIUS = bbe_pkg::MaxRadiusDef,
  localparam int unsigned Depth = 2 * MAX_RADIUS + 1,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  bbe_pkg::pixel_t  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output bbe_pkg::pixel_t  rdata_o
);
  import bbe_pkg::*;

  pixel_t store_q [Depth];
  pixel_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bbe_divider.sv]
// Rounding mean unit: (2*sum + W) / (2*W) for three channels, one quotient bit
// per cycle by restoring division. Depends on bbe_pkg for channel constants.
module bbe_divider #(
  parameter int unsigned MAX_RADIUS = bbe_pkg::MaxRadiusDef,
  localparam int unsigned Depth = 2 * MAX_RADIUS + 1,
  localparam int unsigned SumW  = $clog2(Depth * 255 + 1),
  localparam int unsigned WinW  = $clog2(Depth + 1),
  localparam int unsigned NumW  = $clog2(Depth * 511 + 1),
  localparam int unsigned DivW  = WinW + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SumW-1:0]               sum_i [bbe_pkg::ChanCnt],
  input  logic [WinW-1:0]               win_i,
  output logic                          done_o,
  output logic [bbe_pkg::ChanW-1:0]     quot_o [bbe_pkg::ChanCnt]
);
  import bbe_pkg::*;

  localparam int unsigned CntW = $clog2(ChanW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] den_q;
  logic [DivW-1:0] rem_q [ChanCnt];
  logic [DivW-1:0] rem_d [ChanCnt];
  logic [ChanW-1:0] nq_q [ChanCnt];
  logic [ChanW-1:0] nq_d [ChanCnt];
  logic [NumW-1:0] num  [ChanCnt];
  logic [DivW:0]   rem_sh [ChanCnt];
  logic [DivW:0]   den_ext;
  logic [DivW-1:0] den_new;

  // Numerators at start and one shift-subtract step per channel
  always_comb begin
    den_new = {win_i, 1'b0};
    den_ext = {1'b0, den_q};
    for (int i = 0; i < ChanCnt; i++) begin
      num[i]    = NumW'({sum_i[i], 1'b0}) + NumW'(win_i);
      rem_sh[i] = {rem_q[i], nq_q[i][ChanW-1]};
      if (start_i) begin
        rem_d[i] = DivW'(num[i] >> ChanW);
        nq_d[i]  = num[i][ChanW-1:0];
      end else if (busy_q) begin
        if (rem_sh[i] >= den_ext) begin
          rem_d[i] = DivW'(rem_sh[i] - den_ext);
          nq_d[i]  = {nq_q[i][ChanW-2:0], 1'b1};
        end else begin
          rem_d[i] = DivW'(rem_sh[i]);
          nq_d[i]  = {nq_q[i][ChanW-2:0], 1'b0};
        end
      end else begin
        rem_d[i] = rem_q[i];
        nq_d[i]  = nq_q[i];
      end
    end
  end

  // Step counter and status
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(ChanW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers; the low numerator bits turn into the quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_new;
    end
    rem_q <= rem_d;
    nq_q  <= nq_d;
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

[rtl/bbe_engine.sv]
// Line state and window sequencer: takes pixels, writes the ring store, walks
// each owed window tap by tap and sums it. Depends on bbe_pkg, bbe_stream_if.
module bbe_engine #(
  parameter int unsigned MAX_RADIUS = bbe_pkg::MaxRadiusDef,
  localparam int unsigned Depth = 2 * MAX_RADIUS + 1,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned SumW  = $clog2(Depth * 255 + 1),
  localparam int unsigned WinW  = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bbe_stream_if.sink                  pix_i,
  input  logic [bbe_pkg::RadiusW-1:0] radius_i,
  output logic                        mem_we_o,
  output logic [AddrW-1:0]            mem_waddr_o,
  output bbe_pkg::pixel_t             mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AddrW-1:0]            mem_raddr_o,
  input  bbe_pkg::pixel_t             mem_rdata_i,
  output logic                        div_start_o,
  output logic [SumW-1:0]             sum_o [bbe_pkg::ChanCnt],
  output logic [WinW-1:0]             win_o,
  input  logic                        div_done_i,
  input  logic                        out_free_i,
  output bbe_pkg::res_load_t          load_o
);
  import bbe_pkg::*;

  localparam int unsigned PosW = $clog2(Depth + 1);
  localparam int unsigned RadW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned DW   = RadW + 2;

  eng_state_e state_q, state_d;

  // Control state
  logic [PosW-1:0]  pos_q;
  logic [AddrW-1:0] head_q;
  logic             tap_vld_q;

  // Per-line and per-result working registers
  logic [RadW-1:0]  r_q;
  logic [AddrW-1:0] n_q;
  logic             end_q;
  logic [RadW-1:0]  c_q;
  logic signed [DW-1:0] d_q;
  logic signed [DW-1:0] dend_q;
  logic [AddrW-1:0] rp_q;
  logic [AddrW-1:0] rp_base_q;
  pixel_t           newest_q;
  pixel_t           first_q;
  tap_src_e         tap_src_q;
  logic [SumW-1:0]  sum_q [ChanCnt];

  // Combinational helpers
  logic             accept;
  logic             next_emit;
  logic             more;
  pixel_t           pix_in;
  logic [RadW-1:0]  r_sat;
  logic [PosW-1:0]  pos_inc;
  logic [AddrW-1:0] n_new;
  logic             has_main;
  logic [RadW-1:0]  c_start;
  logic [RadW-1:0]  c_sel;
  logic [RadW-1:0]  r_sel;
  logic signed [DW-1:0] d_first;
  logic signed [DW-1:0] d_last;
  logic signed [DW-1:0] n_s;
  logic [AddrW-1:0] rp_base_new;
  logic [AddrW-1:0] rp_dec;
  tap_src_e         tap_src;
  pixel_t           tap_pix;

  // Values derived from the incoming pixel and the line state
  always_comb begin
    pix_in.blue  = pix_i.payload.blue;
    pix_in.green = pix_i.payload.green;
    pix_in.red   = pix_i.payload.red;
    r_sat    = (32'(radius_i) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : RadW'(radius_i);
    pos_inc  = (pos_q == PosW'(Depth)) ? pos_q : pos_q + PosW'(1);
    n_new    = AddrW'(pos_inc - PosW'(1));
    has_main = ((RadW + 1)'(n_new) >= (RadW + 1)'(r_sat));
    // without a centered output only the flush remains, starting at the newest
    c_start  = has_main ? r_sat : RadW'(n_new);
    rp_base_new = (head_q == '0) ? AddrW'(Depth - 1) : head_q - AddrW'(1);
  end

  // Window bounds of the result about to be gathered
  always_comb begin
    c_sel   = accept ? c_start : c_q - RadW'(1);
    r_sel   = accept ? r_sat : r_q;
    d_first = $signed({2'b00, c_sel}) - $signed({2'b00, r_sel});
    d_last  = $signed({2'b00, c_sel}) + $signed({2'b00, r_sel});
  end

  // Tap classification: at or past the newest, inside the line, or before its start
  always_comb begin
    n_s    = $signed({1'b0, (RadW + 1)'(n_q)});
    rp_dec = (rp_q == '0) ? AddrW'(Depth - 1) : rp_q - AddrW'(1);
    priority if (d_q <= $signed(DW'(0))) begin
      tap_src = SRC_NEWEST;
    end else if (d_q > n_s) begin
      tap_src = SRC_FIRST;
    end else begin
      tap_src = SRC_MEM;
    end
  end

  always_comb begin
    unique case (tap_src_q)
      SRC_NEWEST: tap_pix = newest_q;
      SRC_FIRST:  tap_pix = first_q;
      SRC_MEM:    tap_pix = mem_rdata_i;
      default:    tap_pix = newest_q;
    endcase
  end

  assign more = end_q && (c_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (has_main || pix_i.payload.line_end)) begin
          state_d = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (d_q == dend_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_START;
      ST_START: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done_i && out_free_i) begin
          state_d = more ? ST_GATHER : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pix_i.ready = (state_q == ST_IDLE);
    accept      = pix_i.valid && (state_q == ST_IDLE);
    mem_re_o    = 1'b0;
    div_start_o = 1'b0;
    load_o      = '0;
    unique case (state_q)
      ST_GATHER: mem_re_o = (tap_src == SRC_MEM);
      ST_START:  div_start_o = 1'b1;
      ST_DIVIDE: begin
        load_o.load = div_done_i && out_free_i;
        load_o.last = end_q && (c_q == '0);
      end
      default: ;
    endcase
    next_emit = load_o.load && more;
  end

  assign mem_we_o    = accept;
  assign mem_waddr_o = head_q;
  assign mem_wdata_o = pix_in;
  assign mem_raddr_o = rp_q;
  assign sum_o       = sum_q;
  assign win_o       = WinW'({r_q, 1'b1});

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      head_q    <= '0;
      tap_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_vld_q <= (state_q == ST_GATHER);
      if (accept) begin
        pos_q  <= pix_i.payload.line_end ? '0 : pos_inc;
        head_q <= (head_q == AddrW'(Depth - 1)) ? '0 : head_q + AddrW'(1);
      end
    end
  end

  // Working registers: line capture, window walk and running sums
  always_ff @(posedge clk_i) begin
    tap_src_q <= tap_src;
    if (accept) begin
      r_q       <= r_sat;
      n_q       <= n_new;
      end_q     <= pix_i.payload.line_end;
      newest_q  <= pix_in;
      rp_base_q <= rp_base_new;
      rp_q      <= rp_base_new;
      if (pos_q == '0) begin
        first_q <= pix_in;
      end
    end else if (next_emit) begin
      rp_q <= rp_base_q;
    end else if ((state_q == ST_GATHER) && (tap_src == SRC_MEM)) begin
      rp_q <= rp_dec;
    end

    if (accept || next_emit) begin
      c_q    <= c_sel;
      d_q    <= d_first;
      dend_q <= d_last;
    end else if (state_q == ST_GATHER) begin
      d_q <= d_q + DW'(1);
    end

    // sums restart with each result and take one tap per cycle
    for (int i = 0; i < ChanCnt; i++) begin
      if (accept || next_emit) begin
        sum_q[i] <= '0;
      end
    end
    if (!(accept || next_emit) && tap_vld_q) begin
      sum_q[0] <= sum_q[0] + SumW'(tap_pix.blue);
      sum_q[1] <= sum_q[1] + SumW'(tap_pix.green);
      sum_q[2] <= sum_q[2] + SumW'(tap_pix.red);
    end
  end

endmodule

[rtl/box_blur_edge_replicate_top.sv]
// Edge-replicating box blur over one line of BGR pixels.
// A pixel owing results holds the input until the last of them is loaded, which
// waits while a finished result sits in a full output register. Each result
// takes 2R+1 window taps, a drain and a divider start, 8 divider steps, 1 load.
// A line end owes up to R+1 results, all computed before the next pixel.
// Reset (rst_ni low, asynchronous) sets radius to 1 and opens a new line.
module box_blur_edge_replicate_top #(
  parameter int unsigned MAX_RADIUS = bbe_pkg::MaxRadiusDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bbe_stream_if.sink   cfg_i,
  bbe_stream_if.sink   pix_i,
  bbe_stream_if.source res_o
);
  import bbe_pkg::*;

  localparam int unsigned Depth = 2 * MAX_RADIUS + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SumW  = $clog2(Depth * 255 + 1);
  localparam int unsigned WinW  = $clog2(Depth + 1);

  logic [RadiusW-1:0] radius_q;
  logic               res_valid_q;
  res_req_t           res_q;

  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  pixel_t             mem_wdata;
  logic               mem_re;
  logic [AddrW-1:0]   mem_raddr;
  pixel_t             mem_rdata;
  logic               div_start;
  logic [SumW-1:0]    sums [ChanCnt];
  logic [WinW-1:0]    win;
  logic               div_done;
  logic [ChanW-1:0]   quot [ChanCnt];
  logic               out_free;
  res_load_t          res_load;

  // Radius register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusW'(1);
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.payload;
    end
  end

  bbe_engine #(.MAX_RADIUS(MAX_RADIUS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .radius_i    (radius_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .div_start_o (div_start),
    .sum_o       (sums),
    .win_o       (win),
    .div_done_i  (div_done),
    .out_free_i  (out_free),
    .load_o      (res_load)
  );

  bbe_window_mem #(.MAX_RADIUS(MAX_RADIUS)) u_window_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bbe_divider #(.MAX_RADIUS(MAX_RADIUS)) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sums),
    .win_i   (win),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Output register: holds a finished result while the engine moves on
  assign out_free = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load.load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load.load) begin
      res_q.out_blue      <= quot[0];
      res_q.out_green     <= quot[1];
      res_q.out_red       <= quot[2];
      res_q.out_line_last <= res_load.last;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

endmodule

[rtl/bbe_checker.sv]
// Port-level checks of the box blur: line framing and result timing.
// Depends on box_blur_edge_replicate_top, to which it is bound below.
module bbe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pix_valid_i,
  input logic       pix_ready_i,
  input logic       pix_line_end_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_blue_i,
  input logic [7:0] res_green_i,
  input logic [7:0] res_red_i,
  input logic       res_last_i
);
  logic       pix_acc;
  logic       res_acc;
  logic       end_acc;
  logic       last_acc;
  logic [1:0] lines_owed_q;

  assign pix_acc  = pix_valid_i && pix_ready_i;
  assign res_acc  = res_valid_i && res_ready_i;
  assign end_acc  = pix_acc && pix_line_end_i;
  assign last_acc = res_acc && res_last_i;

  // Line ends taken whose last result has not left yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_owed_q <= 2'd0;
    end else if (end_acc && !last_acc) begin
      lines_owed_q <= lines_owed_q + 2'd1;
    end else if (!end_acc && last_acc) begin
      lines_owed_q <= lines_owed_q - 2'd1;
    end
  end

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_blue_i) &&
    $stable(res_green_i) && $stable(res_red_i) && $stable(res_last_i))
    else $error("stalled result changed");

  // No line-last marker without a line end taken before it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |-> (lines_owed_q != 2'd0))
    else $error("line-last result without a line end");

  // A line end always starts a flush, so the input closes right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc && pix_line_end_i |=> !pix_ready_i)
    else $error("pixel taken during a line-end flush");

  // A result never appears in the cycle right after a pixel is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> !$rose(res_valid_i))
    else $error("result faster than the window walk");

endmodule

bind box_blur_edge_replicate_top bbe_checker u_bbe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pix_valid_i    (pix_i.valid),
  .pix_ready_i    (pix_i.ready),
  .pix_line_end_i (pix_i.payload.line_end),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_blue_i     (res_o.payload.out_blue),
  .res_green_i    (res_o.payload.out_green),
  .res_red_i      (res_o.payload.out_red),
  .res_last_i     (res_o.payload.out_line_last)
);
